[sv/tta_pkg.sv]
// Shared constants and types for the tensor transpose address generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tta_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int ADDR_BITS = 24;
  localparam int DIM_BITS  = 16;
  localparam int AXIS_BITS = 2;
  localparam int DIMC_BITS = 3;
  localparam int CFG_BITS  = 64;
  localparam int CFG_IDX_BITS = 2;
  localparam int PROD_BITS = ADDR_BITS + DIM_BITS;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_COUNT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_DIMS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_DIMS = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_ORDER  = 2'd3;

  // reset values of the configuration registers
  localparam logic [DIMC_BITS-1:0] DIM_COUNT_RST = 3'd4;
  localparam logic [CFG_BITS-1:0]  DIMS_RST      = 64'h0001_0001_0001_0001;
  localparam logic [7:0]           AXIS_ORDER_RST = 8'h1B;

  typedef logic [DIM_BITS-1:0]  pos_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [AXIS_BITS-1:0] axis_t;

endpackage

`default_nettype wire

[sv/tensor_transpose_address_gen.sv]
// Tensor transpose address generator: odometer over the input shape, permuted
// row-major offset into the output shape. Depends on tta_pkg.
//
// Pipeline: an accepted word passes the product stage, then the sum stage into the result word.
// Throughput: one word per cycle; back-pressure stalls the input once both stages are full.
// Output strides come from a shared 24x16 multiplier that walks the axes after
// reset and after every configuration write, with the input stalled meanwhile.
// Reset (rst_n, synchronous): default shape, odometer and count cleared, pipe empty.
`timescale 1ns / 1ps
`default_nettype none

module tensor_transpose_address_gen import tta_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input word channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [31:0]             in_element_bits,
  // result word channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [ADDR_BITS-1:0]         out_dest_offset,
  output logic [31:0]                  out_dest_bits,
  output logic                         out_last_element,
  // configuration write port
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata
);

  // configuration registers
  logic [DIMC_BITS-1:0] dim_count_r;
  logic [CFG_BITS-1:0]  input_dims_r;
  logic [CFG_BITS-1:0]  output_dims_r;
  logic [7:0]           axis_order_r;

  // stride sequencer
  addr_t                 stride_r [MAX_DIMS];
  logic                  seq_busy_r;
  axis_t                 seq_k_r;
  addr_t                 seq_acc_r;
  logic [PROD_BITS-1:0]  seq_prod;
  pos_t                  seq_dim;

  // odometer state
  pos_t                  pos_r   [MAX_DIMS];
  pos_t                  pos_nxt [MAX_DIMS];
  addr_t                 seen_r;
  logic                  last_nxt;

  // pipeline
  logic                  s1_valid_r;
  addr_t                 s1_prod_r [MAX_DIMS];
  addr_t                 prod_nxt  [MAX_DIMS];
  logic [31:0]           s1_bits_r;
  logic                  s1_last_r;
  logic                  out_valid_r;
  addr_t                 out_offset_r;
  addr_t                 offset_sum;
  logic [31:0]           out_bits_r;
  logic                  out_last_r;

  logic                  out_free;
  logic                  s1_free;
  logic                  accept;
  logic [DIMC_BITS-1:0]  n_axes;

  // axes in use: zero acts as one, clamp at MAX_DIMS
  always_comb begin
    if (dim_count_r == '0) begin
      n_axes = DIMC_BITS'(1);
    end else if (dim_count_r > DIMC_BITS'(MAX_DIMS)) begin
      n_axes = DIMC_BITS'(MAX_DIMS);
    end else begin
      n_axes = dim_count_r;
    end
  end

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_stall = seq_busy_r || !s1_free;
  assign accept   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r   <= DIM_COUNT_RST;
      input_dims_r  <= DIMS_RST;
      output_dims_r <= DIMS_RST;
      axis_order_r  <= AXIS_ORDER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM_COUNT:   dim_count_r   <= cfg_wdata[DIMC_BITS-1:0];
        REG_INPUT_DIMS:  input_dims_r  <= cfg_wdata;
        REG_OUTPUT_DIMS: output_dims_r <= cfg_wdata;
        REG_AXIS_ORDER:  axis_order_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // stride walk, innermost axis first: stride[k] = product of output dims past k
  assign seq_dim  = output_dims_r[(MAX_DIMS-1-int'(seq_k_r))*DIM_BITS +: DIM_BITS];
  assign seq_prod = PROD_BITS'(seq_acc_r) * PROD_BITS'(seq_dim);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      seq_busy_r <= 1'b1;
      seq_k_r    <= axis_t'(MAX_DIMS-1);
      seq_acc_r  <= addr_t'(1);
    end else if (seq_busy_r) begin
      if ({1'b0, seq_k_r} < n_axes) begin
        stride_r[seq_k_r] <= seq_acc_r;
        seq_acc_r         <= seq_prod[ADDR_BITS-1:0];
      end
      if (seq_k_r == '0) begin
        seq_busy_r <= 1'b0;
      end
      seq_k_r <= seq_k_r - axis_t'(1);
    end
  end

  // odometer advance, innermost in-use axis first
  always_comb begin
    logic              carry;
    pos_t              size;
    logic [DIM_BITS:0] inc;
    carry = 1'b1;
    for (int i = MAX_DIMS-1; i >= 0; i--) begin
      pos_nxt[i] = pos_r[i];
      size = input_dims_r[(MAX_DIMS-1-i)*DIM_BITS +: DIM_BITS];
      if (size == '0) begin
        size = pos_t'(1);
      end
      inc = {1'b0, pos_r[i]} + (DIM_BITS+1)'(1);
      if ((DIMC_BITS'(i) < n_axes) && carry) begin
        if (inc >= {1'b0, size}) begin
          pos_nxt[i] = '0;
        end else begin
          pos_nxt[i] = inc[DIM_BITS-1:0];
          carry      = 1'b0;
        end
      end
    end
    last_nxt = carry;
  end

  // permuted position times output stride, one multiplier per output axis
  always_comb begin
    axis_t                src;
    pos_t                 psel;
    logic [PROD_BITS-1:0] full;
    for (int i = 0; i < MAX_DIMS; i++) begin
      src  = axis_order_r[(MAX_DIMS-1-i)*AXIS_BITS +: AXIS_BITS];
      psel = ({1'b0, src} < n_axes) ? pos_r[src] : '0;
      full = PROD_BITS'(psel) * PROD_BITS'(stride_r[i]);
      prod_nxt[i] = (DIMC_BITS'(i) < n_axes) ? full[ADDR_BITS-1:0] : '0;
    end
  end

  // odometer and element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        pos_r[i] <= '0;
      end
      seen_r <= '0;
    end else if (accept) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        pos_r[i] <= pos_nxt[i];
      end
      seen_r <= last_nxt ? '0 : seen_r + addr_t'(1);
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        s1_prod_r[i] <= prod_nxt[i];
      end
      s1_bits_r <= in_element_bits;
      s1_last_r <= last_nxt;
    end
  end

  // sum stage into the result register
  always_comb begin
    offset_sum = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      offset_sum = offset_sum + s1_prod_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_offset_r <= offset_sum;
      out_bits_r   <= s1_bits_r;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest_offset  = out_offset_r;
  assign out_dest_bits    = out_bits_r;
  assign out_last_element = out_last_r;

`ifndef SYNTHESIS
  // no word enters while strides are being rebuilt
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !seq_busy_r)
    else $error("word accepted during stride walk");

  // a blocked product stage keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r)
    else $error("product stage word lost");

  // the last element clears the count
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_nxt) |=> (seen_r == '0))
    else $error("element count not cleared after last element");

  // any other element bumps the count by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !last_nxt) |=> (seen_r == $past(seen_r) + addr_t'(1)))
    else $error("element count did not advance");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for tensor_transpose_address_gen: streams tensors through
// several shapes and axis orders and checks every result word against its own predictor.
// Depends on tta_pkg and the tensor_transpose_address_gen RTL.
`timescale 1ns / 1ps

module testbench;
  import tta_pkg::*;

  typedef struct {
    addr_t       offset;
    logic [31:0] bits;
    logic        last;
  } result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // DUT ports; the inputs are driven from time zero
  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic [31:0]             in_element_bits = '0;
  logic                    out_valid;
  logic                    out_stall       = 1'b0;
  addr_t                   out_dest_offset;
  logic [31:0]             out_dest_bits;
  logic                    out_last_element;
  logic                    cfg_we          = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index       = '0;
  logic [CFG_BITS-1:0]     cfg_wdata       = '0;

  tensor_transpose_address_gen dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_bits  (in_element_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dest_offset  (out_dest_offset),
    .out_dest_bits    (out_dest_bits),
    .out_last_element (out_last_element),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // predictor copy of the shape registers and the odometer
  logic [DIMC_BITS-1:0] shape_dim_count  = DIM_COUNT_RST;
  logic [CFG_BITS-1:0]  shape_in_dims    = DIMS_RST;
  logic [CFG_BITS-1:0]  shape_out_dims   = DIMS_RST;
  logic [7:0]           shape_axis_order = AXIS_ORDER_RST;
  pos_t                 odometer [MAX_DIMS];

  result_t expected_words [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned tensor_ends    = 0;
  int unsigned shapes_used    = 1;
  int unsigned mismatches     = 0;

  function automatic int axes_in_use(input logic [DIMC_BITS-1:0] dimc);
    if (dimc == 0) return 1;
    if (dimc > MAX_DIMS) return MAX_DIMS;
    return int'(dimc);
  endfunction

  // permuted row-major offset of the current position, then odometer advance
  function automatic void predict_transpose(input logic [31:0] bits);
    int          n;
    int          src;
    addr_t       offset;
    addr_t       stride;
    pos_t        pos;
    logic [15:0] size;
    logic [16:0] nxt;
    logic        wrap;
    result_t     word;
    n      = axes_in_use(shape_dim_count);
    offset = '0;
    stride = addr_t'(1);
    // innermost output axis first; strides wrap at the address width
    for (int i = n - 1; i >= 0; i--) begin
      src    = int'(shape_axis_order[7 - 2*i -: 2]);
      pos    = (src < n) ? odometer[src] : '0;
      offset = offset + addr_t'(pos) * stride;
      stride = stride * addr_t'(shape_out_dims[63 - 16*i -: 16]);
    end
    // zero-sized axis counts as one; a position past its size wraps with carry
    wrap = 1'b1;
    for (int i = n - 1; i >= 0 && wrap; i--) begin
      size = shape_in_dims[63 - 16*i -: 16];
      if (size == 0) size = 16'd1;
      nxt = {1'b0, odometer[i]} + 17'd1;
      if (nxt >= {1'b0, size}) begin
        odometer[i] = '0;
      end else begin
        odometer[i] = nxt[15:0];
        wrap = 1'b0;
      end
    end
    word.offset = offset;
    word.bits   = bits;
    word.last   = wrap;
    expected_words.push_back(word);
  endfunction

  // result side: random stall, compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_last_element) tensor_ends++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing expected: offset %h bits %h last %b",
                   $realtime, out_dest_offset, out_dest_bits, out_last_element);
      end else begin
        want = expected_words.pop_front();
        if (out_dest_offset !== want.offset || out_dest_bits !== want.bits ||
            out_last_element !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp/act offset %h/%h bits %h/%h last %b/%b", $realtime,
                     want.offset, out_dest_offset, want.bits, out_dest_bits,
                     want.last, out_last_element);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // send one element word; valid stays high across back-to-back words
  task automatic send_word(input logic [31:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_element_bits <= bits;
    do @(posedge clk); while (in_stall);
    predict_transpose(bits);
    words_sent++;
  endtask

  // stop sending and wait until every expected word has come back
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // write all four registers back to back; block must be idle
  task automatic cfg_apply(input logic [DIMC_BITS-1:0] dimc, input logic [63:0] idims,
                           input logic [63:0] odims, input logic [7:0] order);
    cfg_put(REG_DIM_COUNT, CFG_BITS'(dimc));
    cfg_put(REG_INPUT_DIMS, idims);
    cfg_put(REG_OUTPUT_DIMS, odims);
    cfg_put(REG_AXIS_ORDER, CFG_BITS'(order));
    cfg_we           <= 1'b0;
    shape_dim_count  = dimc;
    shape_in_dims    = idims;
    shape_out_dims   = odims;
    shape_axis_order = order;
    shapes_used++;
  endtask

  // default shape: four unit axes, every word is a whole tensor at offset zero
  task automatic test_reset_shape;
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
  endtask

  // 2x3x2 input, output axes taken from input axes 2, 0, 1
  task automatic test_small_transpose;
    drain;
    cfg_apply(3'd3, 64'h0002_0003_0002_0001, 64'h0002_0002_0003_0001, 8'b10_00_01_11);
    for (int k = 0; k < 12; k++) send_word($urandom);
  endtask

  // axis count zero, zero-sized axis, output axis fed from an axis not in use
  task automatic test_degenerate_axes;
    drain;
    cfg_apply(3'd0, 64'h0000_0005_0005_0005, 64'h0000_0000_0000_0000, 8'b11_10_01_00);
    send_word(32'hA5A5_5A5A);
    send_word(32'h5A5A_A5A5);
  endtask

  // axis count above the limit, widest sizes, reversed order: offsets wrap
  task automatic test_offset_wrap;
    drain;
    cfg_apply(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'b11_10_01_00);
    for (int k = 0; k < 4; k++) send_word($urandom);
  endtask

  // shrink the shape while the inner position is past the new size
  task automatic test_shape_change;
    drain;
    cfg_apply(3'd4, 64'h0002_0002_0002_0002, 64'h0002_0002_0002_0002, AXIS_ORDER_RST);
    for (int k = 0; k < 3; k++) send_word($urandom);
  endtask

  // random shapes, mostly true transposes streamed as whole tensors
  task automatic test_random_shapes(input int unsigned goal);
    logic [DIMC_BITS-1:0] dimc;
    logic [63:0]          idims;
    logic [63:0]          odims;
    logic [7:0]           order;
    int unsigned          perm [4];
    int unsigned          n, total, count, sz, j, tmp, src;
    while (goal > 0) begin
      dimc = ($urandom_range(9) == 0) ? DIMC_BITS'($urandom_range(7))
                                      : DIMC_BITS'($urandom_range(1, 4));
      n = axes_in_use(dimc);
      total = 1;
      for (int a = 0; a < 4; a++) begin
        case ($urandom_range(19))
          0:       sz = 0;
          1:       sz = $urandom_range(65535);
          default: sz = $urandom_range(1, 4);
        endcase
        idims[63 - 16*a -: 16] = 16'(sz);
        if (a < n) total = total * ((sz == 0) ? 1 : ((sz > 64) ? 65 : sz));
        if (total > 64) total = 65;
      end
      // permutation over the axes in use, spare slots random
      for (int a = 0; a < 4; a++) perm[a] = (a < n) ? a : $urandom_range(3);
      for (int a = n - 1; a > 0; a--) begin
        j = $urandom_range(a);
        tmp = perm[a];
        perm[a] = perm[j];
        perm[j] = tmp;
      end
      if ($urandom_range(5) == 0) order = 8'($urandom_range(255));
      else order = {2'(perm[0]), 2'(perm[1]), 2'(perm[2]), 2'(perm[3])};
      if ($urandom_range(4) == 0) begin
        odims = {$urandom, $urandom};
      end else begin
        for (int a = 0; a < 4; a++) begin
          src = order[7 - 2*a -: 2];
          odims[63 - 16*a -: 16] = idims[63 - 16*src -: 16];
        end
      end
      drain;
      cfg_apply(dimc, idims, odims, order);
      if (total <= 64) begin
        count = total * $urandom_range(1, 3);
        if ($urandom_range(2) == 0) count = count + $urandom_range(total - 1);
      end else begin
        count = $urandom_range(8, 48);
      end
      if (count > goal) count = goal;
      for (int k = 0; k < count; k++) begin
        case ($urandom_range(15))
          0:       send_word(32'h0000_0000);
          1:       send_word(32'hFFFF_FFFF);
          default: send_word($urandom);
        endcase
      end
      goal = goal - count;
    end
  endtask

  initial begin
    for (int a = 0; a < MAX_DIMS; a++) odometer[a] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_shape;
    test_small_transpose;
    test_degenerate_axes;
    test_offset_wrap;
    test_shape_change;

    send_idle_pct  = 7;
    recv_stall_pct = 84;
    test_random_shapes(580);
    send_idle_pct  = 84;
    recv_stall_pct = 7;
    test_random_shapes(580);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_shapes(580);

    drain;
    repeat (4) @(posedge clk);
    $display("Streamed %0d element words under %0d shape settings; %0d results, %0d tensor ends.",
             words_sent, shapes_used, results_seen, tensor_ends);
    $display("Mismatching or unexpected result words: %0d", mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("Timed out with %0d words still expected", expected_words.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
